// ----- sv/tdh_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and the wraparound deadline compare for the timer heap.
// No dependencies; imported by every other file of the block.
package tdh_pkg;

	localparam int ID_W        = 4;
	localparam int DL_W        = 32;
	localparam int MAX_RESULTS = 16;
	localparam int RES_CW      = $clog2(MAX_RESULTS + 1);

	localparam logic [DL_W-1:0] TMOUT_FOREVER = '1;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_CANCEL = 2'd1;
	localparam logic [1:0] ACT_TICK   = 2'd2;

	localparam logic [2:0] STS_ACCEPTED  = 3'd0;
	localparam logic [2:0] STS_NOEFFECT  = 3'd1;
	localparam logic [2:0] STS_FULL      = 3'd2;
	localparam logic [2:0] STS_DUPLICATE = 3'd3;
	localparam logic [2:0] STS_EXPIRED   = 3'd4;
	localparam logic [2:0] STS_IDLE_TICK = 3'd5;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [DL_W-1:0] dl;
	} slot_t;

	typedef struct packed {
		logic up;
		logic dn;
		logic wr;
	} cell_ctrl_t;

	typedef struct packed {
		logic up_swap;
		logic dn_l;
		logic dn_r;
		logic pick_r;
	} cell_stat_t;

	typedef struct packed {
		logic up;
		logic dn;
		logic wr;
	} row_ctrl_t;

	typedef struct packed {
		logic swap;
		logic pick_r;
		logic hit;
	} row_stat_t;

	function automatic logic dl_before(input logic [DL_W-1:0] a, input logic [DL_W-1:0] b);
		logic [DL_W-1:0] d;
		d = a - b;
		return d[DL_W-1];
	endfunction

endpackage

// ----- sv/tdh_cell.sv -----
`timescale 1ns / 1ps
// One heap slot: holds a handle and its deadline, swaps with parent or child.
// Depends on tdh_pkg.
module tdh_cell import tdh_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  slot_t      wr_data,
	input  logic       is_root,
	input  logic       has_l,
	input  logic       has_r,
	input  slot_t      parent,
	input  slot_t      left,
	input  slot_t      right,
	input  logic       child_up_l,
	input  logic       child_up_r,
	input  logic       par_dn_me,
	output slot_t      q,
	output cell_stat_t stat
);

	slot_t slot_q;
	slot_t child;
	logic  pick_r;
	logic  up_swap;
	logic  dn_swap;

	always_comb begin
		pick_r  = has_r && dl_before(right.dl, left.dl);
		child   = pick_r ? right : left;
		up_swap = ctrl.up && !is_root && dl_before(slot_q.dl, parent.dl);
		dn_swap = ctrl.dn && has_l && dl_before(child.dl, slot_q.dl);
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			slot_q <= wr_data;
		end else if (up_swap) begin
			slot_q <= parent;
		end else if (dn_swap) begin
			slot_q <= child;
		end else if (child_up_l) begin
			slot_q <= left;
		end else if (child_up_r) begin
			slot_q <= right;
		end else if (par_dn_me) begin
			slot_q <= parent;
		end
	end

	assign q = slot_q;
	assign stat = '{up_swap: up_swap, dn_l: dn_swap && !pick_r,
		dn_r: dn_swap && pick_r, pick_r: pick_r};

endmodule

// ----- sv/tdh_cell_row.sv -----
`timescale 1ns / 1ps
// Row of heap cells wired as an implicit binary tree, plus handle match and tail read.
// Depends on tdh_pkg and tdh_cell.
module tdh_cell_row import tdh_pkg::*; #(
	parameter int N  = 16,
	parameter int PW = $clog2(N),
	parameter int CW = $clog2(N + 1)
) (
	input  logic            clk,
	input  logic [CW-1:0]   count,
	input  logic [PW-1:0]   pos,
	input  row_ctrl_t       ctrl,
	input  logic [PW-1:0]   wr_pos,
	input  slot_t           wr_data,
	input  logic [ID_W-1:0] match_id,
	output row_stat_t       stat,
	output logic [PW-1:0]   match_pos,
	output slot_t           top,
	output slot_t           tail
);

	slot_t      q  [N];
	cell_stat_t cs [N];
	logic [N-1:0] up_v;
	logic [N-1:0] dn_v;
	logic [N-1:0] pr_v;
	logic [N-1:0] hit_v;

	for (genvar i = 0; i < N; i++) begin : g_cell
		localparam int P = (i == 0) ? 0 : (i - 1) / 2;
		localparam int L = 2 * i + 1;
		localparam int R = 2 * i + 2;
		cell_ctrl_t cc;
		slot_t      left;
		slot_t      right;
		logic       has_l;
		logic       has_r;
		logic       cul;
		logic       cur;
		logic       pdm;
		logic       sel;

		assign sel = (pos == PW'(i));
		assign cc  = '{up: ctrl.up && sel, dn: ctrl.dn && sel,
			wr: ctrl.wr && (wr_pos == PW'(i))};

		if (L < N) begin : g_l
			assign left  = q[L];
			assign cul   = cs[L].up_swap;
			assign has_l = (count > CW'(L));
		end else begin : g_nl
			assign left  = '0;
			assign cul   = 1'b0;
			assign has_l = 1'b0;
		end

		if (R < N) begin : g_r
			assign right = q[R];
			assign cur   = cs[R].up_swap;
			assign has_r = (count > CW'(R));
		end else begin : g_nr
			assign right = '0;
			assign cur   = 1'b0;
			assign has_r = 1'b0;
		end

		if (i == 0) begin : g_root
			assign pdm = 1'b0;
		end else if (i % 2 == 1) begin : g_lc
			assign pdm = cs[P].dn_l;
		end else begin : g_rc
			assign pdm = cs[P].dn_r;
		end

		tdh_cell u_cell (
			.clk        (clk),
			.ctrl       (cc),
			.wr_data    (wr_data),
			.is_root    (i == 0),
			.has_l      (has_l),
			.has_r      (has_r),
			.parent     (q[P]),
			.left       (left),
			.right      (right),
			.child_up_l (cul),
			.child_up_r (cur),
			.par_dn_me  (pdm),
			.q          (q[i]),
			.stat       (cs[i])
		);

		assign up_v[i]  = cs[i].up_swap;
		assign dn_v[i]  = cs[i].dn_l || cs[i].dn_r;
		assign pr_v[i]  = cs[i].pick_r && sel;
		assign hit_v[i] = (CW'(i) < count) && (q[i].id == match_id);
	end

	logic [CW-1:0] last_idx;

	always_comb begin
		last_idx  = count - CW'(1);
		match_pos = '0;
		tail      = '0;
		for (int i = 0; i < N; i++) begin
			if (hit_v[i]) begin
				match_pos = match_pos | PW'(i);
			end
			if (last_idx == CW'(i)) begin
				tail = q[i];
			end
		end
	end

	assign top  = q[0];
	assign stat = '{swap: (|up_v) || (|dn_v), pick_r: |pr_v, hit: |hit_v};

endmodule

// ----- sv/timeout_deadline_heap_unit.sv -----
`timescale 1ns / 1ps
// Timer queue top level: sequencer over the heap cell row, tick clock, result staging.
// Depends on tdh_pkg, tdh_cell_row and tdh_cell.
//
//   channel | signals                              | role
//   in      | in_valid in_ready action task_id     | one operation per beat
//           | timeout                              |
//   out     | out_valid out_ready task_id_res      | one result per beat, last marks
//           | status last                          | the final result of an operation
//
// Insert writes the new entry at the tail, then sifts it up a level per step. Operations
// without heap work and a cancel of the last slot just stage a result; other cancels move
// the tail entry into the freed slot, sift it down, then sift it up. A tick with nothing
// due stages an idle-tick result; otherwise each expired entry is popped and the tail entry
// goes to the root and sifts down if any remain. The row has a single sift step.
// Reset clears the count, clock and queued state at once; no clearing pass.
// A result waiting in the staging register blocks new input; a tick parks its next pop
// in the hold register and stalls there until the staging register frees.
module timeout_deadline_heap_unit import tdh_pkg::*; #(
	parameter int MAX_TASKS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      action,
	input  logic [ID_W-1:0] task_id,
	input  logic [DL_W-1:0] timeout,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [ID_W-1:0] task_id_res,
	output logic [2:0]      status,
	output logic            last
);

	localparam int PW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_UP, ST_DOWN, ST_CHECK} fsm_t;

	fsm_t              state_q;
	logic [CW-1:0]     count_q;
	logic [DL_W-1:0]   now_q;
	logic [PW-1:0]     pos_q;
	logic [PW-1:0]     org_q;
	logic              tick_q;
	logic [RES_CW-1:0] n_q;
	logic              hold_v_q;
	logic [ID_W-1:0]   hold_id_q;
	logic              pend_v_q;
	logic [ID_W-1:0]   pend_id_q;
	logic [2:0]        pend_st_q;
	logic              pend_last_q;
	logic              out_v_q;
	logic [ID_W-1:0]   out_id_q;
	logic [2:0]        out_st_q;
	logic              out_last_q;

	row_ctrl_t     ctrl;
	logic [PW-1:0] wr_pos;
	slot_t         wr_data;
	row_stat_t     rst;
	logic [PW-1:0] match_pos;
	slot_t         top;
	slot_t         tail;

	logic          acc;
	logic          out_free;
	logic          id_ok;
	logic          full;
	logic          due;
	logic          ins_go;
	logic          can_go;
	logic          pop_go;
	logic [2:0]    res_st;
	logic [CW-1:0] cnt_m1;
	logic [PW-1:0] last_pos;
	logic [PW:0]   child_w;
	logic [PW-1:0] pos_m1;
	logic [PW-1:0] par_pos;

	tdh_cell_row #(.N(MAX_TASKS), .PW(PW), .CW(CW)) u_row (
		.clk       (clk),
		.count     (count_q),
		.pos       (pos_q),
		.ctrl      (ctrl),
		.wr_pos    (wr_pos),
		.wr_data   (wr_data),
		.match_id  (task_id),
		.stat      (rst),
		.match_pos (match_pos),
		.top       (top),
		.tail      (tail)
	);

	assign in_ready = (state_q == ST_IDLE) && !pend_v_q;
	assign acc      = in_valid && in_ready;
	assign out_free = !out_v_q || out_ready;

	always_comb begin
		cnt_m1   = count_q - CW'(1);
		last_pos = cnt_m1[PW-1:0];
		child_w  = {pos_q, 1'b1} + {{PW{1'b0}}, rst.pick_r};
		pos_m1   = pos_q - PW'(1);
		par_pos  = pos_m1 >> 1;
		id_ok    = ({28'd0, task_id} < 32'(MAX_TASKS));
		full     = (count_q >= CW'(MAX_TASKS));
		due      = (count_q != '0) && (n_q < RES_CW'(MAX_RESULTS)) &&
			!dl_before(now_q, top.dl);
		pop_go   = (state_q == ST_CHECK) && !hold_v_q && due;

		res_st = STS_NOEFFECT;
		ins_go = 1'b0;
		can_go = 1'b0;
		case (action)
			ACT_INSERT: begin
				if (id_ok) begin
					if (rst.hit) begin
						res_st = STS_DUPLICATE;
					end else if (timeout == TMOUT_FOREVER) begin
						res_st = STS_ACCEPTED;
					end else if (full) begin
						res_st = STS_FULL;
					end else begin
						res_st = STS_ACCEPTED;
						ins_go = 1'b1;
					end
				end
			end
			ACT_CANCEL: begin
				if (id_ok && rst.hit) begin
					res_st = STS_ACCEPTED;
					can_go = 1'b1;
				end
			end
			default: begin
				res_st = STS_NOEFFECT;
			end
		endcase

		ctrl    = '0;
		wr_pos  = count_q[PW-1:0];
		wr_data = '{id: task_id, dl: now_q + timeout};
		case (state_q)
			ST_IDLE: begin
				if (acc && ins_go) begin
					ctrl.wr = 1'b1;
				end else if (acc && can_go && match_pos != last_pos) begin
					ctrl.wr = 1'b1;
					wr_pos  = match_pos;
					wr_data = tail;
				end
			end
			ST_UP: begin
				ctrl.up = 1'b1;
			end
			ST_DOWN: begin
				ctrl.dn = 1'b1;
			end
			ST_CHECK: begin
				if (pop_go && count_q != CW'(1)) begin
					ctrl.wr = 1'b1;
					wr_pos  = '0;
					wr_data = tail;
				end
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			now_q    <= '0;
			pos_q    <= '0;
			org_q    <= '0;
			tick_q   <= 1'b0;
			n_q      <= '0;
			hold_v_q <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (pend_v_q && out_free) begin
				out_v_q    <= 1'b1;
				out_id_q   <= pend_id_q;
				out_st_q   <= pend_st_q;
				out_last_q <= pend_last_q;
				pend_v_q   <= 1'b0;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (action == ACT_TICK) begin
							now_q   <= now_q + DL_W'(1);
							n_q     <= '0;
							state_q <= ST_CHECK;
						end else begin
							pend_v_q    <= 1'b1;
							pend_id_q   <= task_id;
							pend_st_q   <= res_st;
							pend_last_q <= 1'b1;
							if (ins_go) begin
								count_q <= count_q + CW'(1);
								pos_q   <= count_q[PW-1:0];
								state_q <= ST_UP;
							end else if (can_go) begin
								count_q <= cnt_m1;
								if (match_pos != last_pos) begin
									pos_q   <= match_pos;
									org_q   <= match_pos;
									tick_q  <= 1'b0;
									state_q <= ST_DOWN;
								end
							end
						end
					end
				end
				ST_UP: begin
					if (rst.swap) begin
						pos_q <= par_pos;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DOWN: begin
					if (rst.swap) begin
						pos_q <= child_w[PW-1:0];
					end else if (tick_q) begin
						state_q <= ST_CHECK;
					end else begin
						pos_q   <= org_q;
						state_q <= ST_UP;
					end
				end
				ST_CHECK: begin
					if (hold_v_q) begin
						if (!pend_v_q) begin
							pend_v_q    <= 1'b1;
							pend_id_q   <= hold_id_q;
							pend_st_q   <= STS_EXPIRED;
							pend_last_q <= !due;
							hold_v_q    <= 1'b0;
							if (!due) begin
								state_q <= ST_IDLE;
							end
						end
					end else if (due) begin
						hold_v_q  <= 1'b1;
						hold_id_q <= top.id;
						n_q       <= n_q + RES_CW'(1);
						count_q   <= cnt_m1;
						if (count_q != CW'(1)) begin
							pos_q   <= '0;
							tick_q  <= 1'b1;
							state_q <= ST_DOWN;
						end
					end else if (!pend_v_q) begin
						pend_v_q    <= 1'b1;
						pend_id_q   <= '0;
						pend_st_q   <= STS_IDLE_TICK;
						pend_last_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_v_q;
	assign task_id_res = out_id_q;
	assign status      = out_st_q;
	assign last        = out_last_q;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for timeout_deadline_heap_unit: directed and random timer operations,
// with an in-bench deadline heap predicting every result beat. Depends on tdh_pkg and the RTL.
module tb_top;
	import tdh_pkg::*;

	localparam int N_TASKS = 16;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int N_ITEMS = 470;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 64;

	typedef struct {
		logic [1:0]      act;
		logic [ID_W-1:0] id;
		logic [DL_W-1:0] tmo;
		int              gap;
		bit              drain_first;
	} op_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [2:0]      st;
		logic            fin;
	} beat_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_ready;
	logic [1:0]      action = ACT_INSERT;
	logic [ID_W-1:0] task_id = '0;
	logic [DL_W-1:0] timeout = '0;
	logic            out_valid;
	logic            out_ready = 1'b0;
	logic [ID_W-1:0] task_id_res;
	logic [2:0]      status;
	logic            last;

	op_t   pending_ops[$];
	beat_t want_beats[$];
	op_t   head_op;
	beat_t got_exp;

	logic [ID_W-1:0] heap_task[N_TASKS];
	logic [ID_W-1:0] heap_pos[N_TASKS];
	logic            queued[N_TASKS];
	logic [DL_W-1:0] due_at[N_TASKS];
	int              n_queued;
	logic [DL_W-1:0] now_tick;

	int n_made, n_accepted, n_checked, n_errors;
	int n_inserted, n_cancelled, n_ticks, n_expired, max_burst;
	int tx_max, tx_wait;
	bit gap_armed;
	int rx_max, rx_wait, hold_left;
	bit hold_done;

	timeout_deadline_heap_unit #(.MAX_TASKS(N_TASKS)) dut (
		.clk, .arst_n,
		.in_valid, .in_ready, .action, .task_id, .timeout,
		.out_valid, .out_ready, .task_id_res, .status, .last
	);

	always #5 clk = ~clk;

	function automatic logic due_earlier(input logic [DL_W-1:0] a, input logic [DL_W-1:0] b);
		logic [DL_W-1:0] d;
		d = a - b;
		return d[DL_W-1];
	endfunction

	function automatic logic slot_earlier(input int i, input int j);
		return due_earlier(due_at[heap_task[i]], due_at[heap_task[j]]);
	endfunction

	function automatic void swap_slots(input int i, input int j);
		logic [ID_W-1:0] t;
		t = heap_task[i];
		heap_task[i] = heap_task[j];
		heap_task[j] = t;
		heap_pos[heap_task[i]] = i[ID_W-1:0];
		heap_pos[heap_task[j]] = j[ID_W-1:0];
	endfunction

	function automatic void sift_up(input int p);
		int par;
		bit go;
		go = 1'b1;
		while (go && p > 0) begin
			par = (p - 1) / 2;
			if (slot_earlier(p, par)) begin
				swap_slots(p, par);
				p = par;
			end else begin
				go = 1'b0;
			end
		end
	endfunction

	function automatic void sift_down(input int p);
		int l, c;
		bit go;
		go = 1'b1;
		while (go) begin
			l = 2 * p + 1;
			if (l >= n_queued) begin
				go = 1'b0;
			end else begin
				c = l;
				if (l + 1 < n_queued && slot_earlier(l + 1, l))
					c = l + 1;
				if (slot_earlier(c, p)) begin
					swap_slots(p, c);
					p = c;
				end else begin
					go = 1'b0;
				end
			end
		end
	endfunction

	function automatic void remove_slot(input int p);
		queued[heap_task[p]] = 1'b0;
		n_queued--;
		if (p != n_queued) begin
			heap_task[p] = heap_task[n_queued];
			heap_pos[heap_task[p]] = p[ID_W-1:0];
			sift_down(p);
			sift_up(p);
		end
	endfunction

	function automatic void expect_beat(input logic [ID_W-1:0] id, input logic [2:0] st,
			input logic fin);
		beat_t b;
		b.id = id;
		b.st = st;
		b.fin = fin;
		want_beats.push_back(b);
	endfunction

	// advance the timer heap by one operation and queue the beats it must produce
	function automatic void apply_timer_op(input logic [1:0] act, input logic [ID_W-1:0] id,
			input logic [DL_W-1:0] tmo);
		logic [2:0]      st;
		logic [ID_W-1:0] top;
		logic [ID_W-1:0] popped[MAX_RESULTS];
		int              n;
		bit              go;
		n_accepted++;
		if (act == ACT_TICK) begin
			n_ticks++;
			now_tick = now_tick + DL_W'(1);
			n = 0;
			go = 1'b1;
			while (go && n_queued > 0 && n < MAX_RESULTS) begin
				top = heap_task[0];
				if (due_earlier(now_tick, due_at[top])) begin
					go = 1'b0;
				end else begin
					remove_slot(0);
					popped[n] = top;
					n++;
				end
			end
			if (n == 0)
				expect_beat('0, STS_IDLE_TICK, 1'b1);
			for (int k = 0; k < n; k++)
				expect_beat(popped[k], STS_EXPIRED, k == n - 1);
			n_expired += n;
			if (n > max_burst)
				max_burst = n;
		end else begin
			st = STS_NOEFFECT;
			if (act == ACT_INSERT && int'(id) < N_TASKS) begin
				if (queued[id]) begin
					st = STS_DUPLICATE;
				end else if (tmo == TMOUT_FOREVER) begin
					st = STS_ACCEPTED;
				end else if (n_queued >= N_TASKS) begin
					st = STS_FULL;
				end else begin
					due_at[id] = now_tick + tmo;
					heap_task[n_queued] = id;
					heap_pos[id] = n_queued[ID_W-1:0];
					queued[id] = 1'b1;
					n_queued++;
					sift_up(n_queued - 1);
					st = STS_ACCEPTED;
					n_inserted++;
				end
			end else if (act == ACT_CANCEL && int'(id) < N_TASKS && queued[id]) begin
				if (int'(heap_pos[id]) < n_queued)
					remove_slot(int'(heap_pos[id]));
				else
					queued[id] = 1'b0;
				st = STS_ACCEPTED;
				n_cancelled++;
			end
			expect_beat(id, st, 1'b1);
		end
	endfunction

	function automatic void push_op(input logic [1:0] act, input logic [ID_W-1:0] id,
			input logic [DL_W-1:0] tmo, input bit drain_first);
		op_t o;
		o.act = act;
		o.id = id;
		o.tmo = tmo;
		o.gap = $urandom_range(0, tx_max);
		o.drain_first = drain_first;
		pending_ops.push_back(o);
		n_made++;
	endfunction

	function automatic logic [DL_W-1:0] pick_timeout();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return $urandom_range(0, 40);
		else if (r < 65)
			return TMOUT_FOREVER;
		else if (r < 75)
			return 32'h7FFF_FFF0 + $urandom_range(0, 31);
		else if (r < 85)
			return 32'hFFFF_FFE0 + $urandom_range(0, 30);
		else
			return $urandom;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= ACT_INSERT;
			task_id <= '0;
			timeout <= '0;
			tx_wait = 0;
			gap_armed = 1'b0;
		end else begin
			if (in_valid && in_ready)
				apply_timer_op(action, task_id, timeout);
			if (!in_valid || in_ready) begin
				if (tx_wait > 0) begin
					tx_wait--;
					in_valid <= 1'b0;
				end else if (pending_ops.size() == 0 ||
						(pending_ops[0].drain_first && want_beats.size() != 0)) begin
					in_valid <= 1'b0;
				end else if (!gap_armed && pending_ops[0].gap > 0) begin
					tx_wait = pending_ops[0].gap - 1;
					gap_armed = 1'b1;
					in_valid <= 1'b0;
				end else begin
					head_op = pending_ops.pop_front();
					gap_armed = 1'b0;
					in_valid <= 1'b1;
					action <= head_op.act;
					task_id <= head_op.id;
					timeout <= head_op.tmo;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait = 0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (want_beats.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("tb_top: unexpected beat id=%0d status=%0d last=%0b",
							task_id_res, status, last);
				end else begin
					got_exp = want_beats.pop_front();
					n_checked++;
					if (got_exp.id !== task_id_res || got_exp.st !== status ||
							got_exp.fin !== last) begin
						n_errors++;
						if (n_errors <= 10)
							$display({"tb_top: beat %0d expected id=%0d status=%0d",
								" last=%0b, got id=%0d status=%0d last=%0b"},
								n_checked, got_exp.id, got_exp.st, got_exp.fin,
								task_id_res, status, last);
					end
				end
				if (n_checked % 40 == 0)
					rx_max = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 4 : 18);
				rx_wait = $urandom_range(0, rx_max);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && n_accepted >= 60) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int mode, len, r;
		bit drain;
		logic [1:0] a;
		for (int k = 0; k < N_TASKS; k++) begin
			heap_task[k] = '0;
			heap_pos[k] = '0;
			queued[k] = 1'b0;
			due_at[k] = '0;
		end
		n_queued = 0;
		now_tick = '0;
		rx_max = 0;
		tx_max = 18;

		push_op(ACT_TICK, 4'd0, '0, 1'b0);
		push_op(ACT_INSERT, 4'd0, 32'd0, 1'b0);
		push_op(ACT_INSERT, 4'd15, TMOUT_FOREVER, 1'b0);
		push_op(ACT_INSERT, 4'd0, 32'd5, 1'b0);
		push_op(ACT_CANCEL, 4'd15, 32'd0, 1'b0);
		push_op(ACT_UNUSED, 4'd10, TMOUT_FOREVER, 1'b0);
		push_op(ACT_INSERT, 4'd15, 32'hFFFF_FFFE, 1'b0);
		push_op(ACT_TICK, 4'd15, 32'hFFFF_FFFF, 1'b0);
		// fill every handle with one deadline so a single tick pops the whole heap
		for (int k = N_TASKS - 1; k >= 0; k--)
			push_op(ACT_INSERT, k[ID_W-1:0], 32'd1, 1'b0);
		push_op(ACT_TICK, 4'd0, '0, 1'b0);

		drain = 1'b1;
		while (n_made < N_ITEMS) begin
			mode = $urandom_range(0, 2);
			len = $urandom_range(10, 40);
			r = $urandom_range(0, 2);
			tx_max = (r == 0) ? 0 : ((r == 1) ? 3 : 18);
			for (int k = 0; k < len && n_made < N_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				case (mode)
				0: begin
					a = (r < 70) ? ACT_INSERT : (r < 80) ? ACT_CANCEL :
						(r < 98) ? ACT_TICK : ACT_UNUSED;
				end
				1: begin
					a = (r < 10) ? ACT_INSERT : (r < 40) ? ACT_CANCEL :
						(r < 98) ? ACT_TICK : ACT_UNUSED;
				end
				default: begin
					a = (r < 40) ? ACT_INSERT : (r < 65) ? ACT_CANCEL :
						(r < 95) ? ACT_TICK : ACT_UNUSED;
				end
				endcase
				push_op(a, ID_W'($urandom_range(0, N_TASKS - 1)),
					(a == ACT_INSERT) ? pick_timeout() : $urandom, drain && k == 0);
			end
			drain = ($urandom_range(0, 3) == 0);
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_ops.size() != 0 || in_valid || want_beats.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("tb_top: %0d operations (%0d inserts queued, %0d cancels, %0d ticks)",
			n_accepted, n_inserted, n_cancelled, n_ticks);
		$display("tb_top: %0d beats, %0d expiries, up to %0d on one tick, %0d mismatches",
			n_checked, n_expired, max_burst, n_errors);
		if (n_errors == 0 && want_beats.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_top: timed out, %0d beats outstanding", want_beats.size());
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
